>>> rtl/core/fcw_pkg.sv
// Shared types and constants for the FAT12 cluster chain walker.
package fcw_pkg;

  localparam int CLUSTER_W = 12;
  localparam int SIZE_W    = 24;
  localparam int SECTOR_W  = 16;
  localparam int COUNT_W   = 10;
  localparam int IDX_W     = 13;
  localparam int STATUS_W  = 2;
  localparam int IN_DATA_W = 72;
  localparam int OUT_DATA_W = 32;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_EXTRACT = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TRUNC = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  localparam logic [CLUSTER_W-1:0] END_MARK  = 12'hFFF;
  localparam logic [CLUSTER_W-1:0] FREE_MARK = 12'h000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_CHECK
  } fcw_state_t;

  typedef struct packed {
    logic                start;
    logic                wr;
    logic                step;
    logic                rd;
    logic                push;
    logic                late;
    logic                last;
    logic [STATUS_W-1:0] status;
    logic                advance;
  } fcw_cmd_t;

  typedef struct packed {
    logic rem_done;
    logic idx_oob;
    logic go;
    logic run_full;
  } fcw_sts_t;

endpackage

>>> rtl/core/fcw_ctrl.sv
// Controller state machine for the FAT12 cluster chain walker.
module fcw_ctrl
  import fcw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  logic     in_tuser,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  fcw_sts_t sts,
  output fcw_cmd_t cmd
);

  fcw_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser == FUNC_EXTRACT) begin
            cmd.start = 1'b1;
            state_nxt = ST_EMIT;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.step = 1'b1;
          if (sts.rem_done || sts.idx_oob) begin
            cmd.push   = 1'b1;
            cmd.last   = 1'b1;
            cmd.status = sts.rem_done ? STATUS_OK : STATUS_RANGE;
            state_nxt  = ST_IDLE;
          end else begin
            cmd.rd    = 1'b1;
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (out_free) begin
          cmd.push = 1'b1;
          cmd.late = 1'b1;
          if (!sts.go) begin
            cmd.last   = 1'b1;
            cmd.status = STATUS_OK;
            state_nxt  = ST_IDLE;
          end else if (sts.run_full) begin
            cmd.last   = 1'b1;
            cmd.status = STATUS_TRUNC;
            state_nxt  = ST_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = ST_EMIT;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = cmd.push ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (!out_valid_r || out_tready))
    else $error("result pushed over an untaken result");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push && cmd.last) |=> (state_r == ST_IDLE))
    else $error("run did not end after final result");

  a_rd_check: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |=> (state_r == ST_CHECK))
    else $error("table read not followed by check");

  a_status_final: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push && !cmd.last) |-> (cmd.status == STATUS_OK))
    else $error("nonzero status on a non-final result");

endmodule

>>> rtl/core/fcw_datapath.sv
// Datapath: FAT banks, walk registers and output register.
module fcw_datapath
  import fcw_pkg::*;
#(
  parameter int FAT_ENTRIES  = 512,
  parameter int MAX_RUN      = 64,
  parameter int SECTOR_BYTES = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wen,
  input  logic [SECTOR_W-1:0]   cfg_wdata,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  fcw_cmd_t              cmd,
  output fcw_sts_t              sts,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  output logic [STATUS_W-1:0]   out_tuser
);

  localparam int BANK_DEPTH = (FAT_ENTRIES + 1) / 2;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);
  localparam int RUN_W      = $clog2(MAX_RUN + 1);
  localparam int TAKE_W     = $clog2(SECTOR_BYTES + 1);
  localparam logic [RUN_W-1:0]  RUN_LAST  = RUN_W'(MAX_RUN - 1);
  localparam logic [SIZE_W-1:0] SECT_SIZE = SIZE_W'(SECTOR_BYTES);
  localparam logic [IDX_W-1:0]  FAT_LIM   = IDX_W'(FAT_ENTRIES);

  logic [CLUSTER_W-1:0] even_mem [BANK_DEPTH];
  logic [CLUSTER_W-1:0] odd_mem  [BANK_DEPTH];

  logic [SECTOR_W-1:0]  base_r;
  logic [CLUSTER_W-1:0] cl_r;
  logic [SIZE_W-1:0]    rem_r;
  logic                 del_r;
  logic [RUN_W-1:0]     n_r;
  logic [CLUSTER_W-1:0] rd_even_r, rd_odd_r;
  logic                 odd_sel_r;
  logic [SECTOR_W-1:0]  pend_sector_r;
  logic [COUNT_W-1:0]   pend_count_r;
  logic [SECTOR_W-1:0]  out_sector_r;
  logic [COUNT_W-1:0]   out_count_r;
  logic                 out_last_r;
  logic [STATUS_W-1:0]  out_status_r;

  logic [7:0]           t_idx;
  logic [IDX_W-1:0]     t_ext, e0, e1, idx;
  logic [CLUSTER_W-1:0] even_entry, odd_entry, entry;
  logic [TAKE_W-1:0]    take;
  logic [SECTOR_W-1:0]  sector;
  logic [COUNT_W-1:0]   count;
  logic [BANK_AW-1:0]   wr_addr, rd_addr;

  assign t_idx      = in_tdata[7:0];
  assign t_ext      = {{(IDX_W-8){1'b0}}, t_idx};
  assign e0         = {t_ext[IDX_W-2:0], 1'b0};
  assign e1         = {t_ext[IDX_W-2:0], 1'b1};
  assign wr_addr    = t_ext[BANK_AW-1:0];
  assign even_entry = {in_tdata[19:16], in_tdata[15:8]};
  assign odd_entry  = {in_tdata[31:24], in_tdata[23:20]};

  assign idx     = del_r ? ({1'b0, cl_r} + 13'd1) : {1'b0, cl_r};
  assign rd_addr = idx[BANK_AW:1];
  assign take    = (rem_r >= SECT_SIZE) ? TAKE_W'(SECTOR_BYTES) : rem_r[TAKE_W-1:0];
  assign sector  = base_r + {{(SECTOR_W-CLUSTER_W){1'b0}}, cl_r} - 16'd2;
  assign count   = COUNT_W'(take);
  assign entry   = odd_sel_r ? rd_odd_r : rd_even_r;

  assign sts.rem_done = (rem_r <= SECT_SIZE);
  assign sts.idx_oob  = (idx >= FAT_LIM);
  assign sts.go       = del_r ? (entry == FREE_MARK) : (entry != END_MARK);
  assign sts.run_full = (n_r >= RUN_LAST);

  always_ff @(posedge clk) begin
    if (cmd.wr && (e0 < FAT_LIM)) begin
      even_mem[wr_addr] <= even_entry;
    end
    if (cmd.wr && (e1 < FAT_LIM)) begin
      odd_mem[wr_addr] <= odd_entry;
    end
    if (cmd.rd) begin
      rd_even_r <= even_mem[rd_addr];
      rd_odd_r  <= odd_mem[rd_addr];
      odd_sel_r <= idx[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= 16'd33;
    end else if (cfg_wen) begin
      base_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cl_r  <= in_tdata[43:32];
      rem_r <= in_tdata[67:44];
      del_r <= in_tdata[68];
      n_r   <= '0;
    end else begin
      if (cmd.step) begin
        rem_r         <= rem_r - SIZE_W'(take);
        pend_sector_r <= sector;
        pend_count_r  <= count;
      end
      if (cmd.advance) begin
        cl_r <= del_r ? (cl_r + 12'd1) : entry;
        n_r  <= n_r + RUN_W'(1);
      end
    end
    if (cmd.push) begin
      out_sector_r <= cmd.late ? pend_sector_r : sector;
      out_count_r  <= cmd.late ? pend_count_r : count;
      out_last_r   <= cmd.last;
      out_status_r <= cmd.status;
    end
  end

  assign out_tdata = {{(OUT_DATA_W-SECTOR_W-COUNT_W){1'b0}}, out_count_r, out_sector_r};
  assign out_tlast = out_last_r;
  assign out_tuser = out_status_r;

endmodule

>>> rtl/core/fat12_cluster_chain_walker_unit.sv
// Top level of the FAT12 cluster chain walker.
// Input stream: in_tuser selects the item. A load (0) unpacks a three-byte FAT
// group into table entries 2i and 2i+1 in the accepting cycle; loads transfer
// one per cycle. An extract (1) walks one file and produces one output transfer
// per cluster: sector number and byte count in out_tdata, out_tlast on the
// final result, the run status in out_tuser.
// A result that continues the walk passes through EMIT, which forms the byte
// count and issues the table read, and then CHECK, which checks the registered
// entry from the even/odd FAT banks. A final result that ends the run because
// the size is used up or the next entry lies beyond the table is pushed from
// EMIT without the read; so the first result comes from EMIT when the run ends
// at its first cluster, else from CHECK. in_tready is low while a run is in
// progress.
// The result sits in an output register; the block takes the next input while
// the final result still waits there, and a stalled receiver only holds the
// walk at its next result.
// Reset sets the data area base sector to 33 and empties the pipeline; the
// FAT contents are undefined until loaded, and a walk needs no clearing pass.
// cfg_wen writes cfg_wdata to the base sector register; write only when idle.
module fat12_cluster_chain_walker_unit
  import fcw_pkg::*;
#(
  parameter int FAT_ENTRIES  = 512,
  parameter int MAX_RUN      = 64,
  parameter int SECTOR_BYTES = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wen,
  input  logic [SECTOR_W-1:0]   cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // triplet_index, packed_byte0, packed_byte1, packed_byte2,
  // start_cluster, file_size, deleted
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // func
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // sector_number, byte_count
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  // status
  output logic [STATUS_W-1:0]   out_tuser
);

  fcw_cmd_t cmd;
  fcw_sts_t sts;

  fcw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  fcw_datapath #(
    .FAT_ENTRIES  (FAT_ENTRIES),
    .MAX_RUN      (MAX_RUN),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

endmodule
